// File: design/rret_pkg.sv
// Shared types and codes for the ranked station table.
`default_nettype none
package rret_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [47:0] STALE_RST = 48'd5000000;
    localparam logic [47:0] REMOVAL_RST = 48'd30000000;

    localparam logic [7:0] CFG_STALE = 8'd0;
    localparam logic [7:0] CFG_REMOVAL = 8'd1;

    localparam logic [2:0] OUT_REFRESH = 3'd0;
    localparam logic [2:0] OUT_INSERT = 3'd1;
    localparam logic [2:0] OUT_REPLACE = 3'd2;
    localparam logic [2:0] OUT_DROP = 3'd3;
    localparam logic [2:0] OUT_SWEEP = 3'd4;

    typedef struct packed {
        logic [47:0]        bssid;
        logic signed [7:0]  rssi;
        logic [7:0]         channel;
        logic [31:0]        variance;
        logic [47:0]        last_seen;
        logic [31:0]        frames;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_BEST  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// File: design/rssi_ranked_entry_table_with_aging.sv
// Top level of the ranked station table with aging.
//
//  channel | direction | handshake           | word
//  s_      | in        | s_valid / s_ready   | mode, now, frame fields
//  m_      | out       | m_valid / m_ready   | outcome, strongest entry, count
//  cfg_    | in        | cfg_valid/cfg_ready | register index, data
//
// An item holds the block from accept to the next accept: the accept state, an update scan
// (one read a cycle), a write-back state, a ranking scan and an output state, in that order;
// the result is registered as the block leaves the output state. Reset clears all slots at
// once through valid bits; no clearing pass. A held result stalls the next item in its
// output state only.
`default_nettype none
module rssi_ranked_entry_table_with_aging #(
    parameter int ENTRIES = rret_pkg::ENTRIES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    input  wire logic [47:0]       s_now_us,
    input  wire logic [47:0]       s_frame_bssid,
    input  wire logic signed [7:0] s_frame_rssi,
    input  wire logic [7:0]        s_frame_channel,
    input  wire logic [31:0]       s_frame_variance,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_outcome,
    output logic                   m_found,
    output logic [3:0]             m_best_index,
    output logic [47:0]            m_best_bssid,
    output logic signed [7:0]      m_best_rssi,
    output logic [7:0]             m_best_channel,
    output logic [31:0]            m_best_variance,
    output logic [31:0]            m_best_frames,
    output logic [4:0]             m_occupied_count,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [47:0]       cfg_data
);
    import rret_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] active_reg, active_next;
    logic [CW-1:0] count_reg, count_next;
    logic [47:0] stale_reg, removal_reg;

    logic mode_reg;
    logic [47:0] now_reg, bssid_reg;
    logic signed [7:0] rssi_reg;
    logic [7:0] chan_reg;
    logic [31:0] var_reg;

    logic match_reg, match_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [31:0] match_frames_reg, match_frames_next;
    logic free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] weak_idx_reg, weak_idx_next;
    logic signed [7:0] weak_rssi_reg, weak_rssi_next;
    logic [2:0] outcome_reg, outcome_next;
    logic have_reg, have_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    entry_t best_reg, best_next;

    logic m_valid_reg;
    logic [2:0] m_outcome_reg;
    logic m_found_reg;
    logic [3:0] m_index_reg;
    entry_t m_entry_reg;
    logic [4:0] m_count_reg;

    logic wr_en, clr_en;
    logic [IW-1:0] wr_addr, clr_addr;
    entry_t wr_data, rd_data;
    logic [47:0] age;
    logic scan_end;

    rret_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .clr_en(clr_en), .clr_addr(clr_addr),
        .rd_addr(cnt_reg[IW-1:0]), .rd_data(rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign age = now_reg - rd_data.last_seen;
    assign scan_end = (cnt_reg == CW'(ENTRIES)) && !rd_vld_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = cnt_reg[IW-1:0];
        active_next = active_reg;
        count_next = count_reg;
        match_next = match_reg;
        match_idx_next = match_idx_reg;
        match_frames_next = match_frames_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        weak_idx_next = weak_idx_reg;
        weak_rssi_next = weak_rssi_reg;
        outcome_next = outcome_reg;
        have_next = have_reg;
        best_idx_next = best_idx_reg;
        best_next = best_reg;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        clr_en = 1'b0;
        clr_addr = rd_idx_reg;
        if ((state_reg == ST_SCAN || state_reg == ST_BEST) && cnt_reg != CW'(ENTRIES)) begin
            rd_vld_next = 1'b1;
            cnt_next = cnt_reg + CW'(1);
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                    cnt_next = '0;
                    match_next = 1'b0;
                    free_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg) begin
                    if (mode_reg) begin
                        if (active_reg[rd_idx_reg]) begin
                            if (age > removal_reg) begin
                                clr_en = 1'b1;
                                active_next[rd_idx_reg] = 1'b0;
                                if (count_reg != '0) begin
                                    count_next = count_reg - CW'(1);
                                end
                            end else if (age > stale_reg) begin
                                active_next[rd_idx_reg] = 1'b0;
                            end
                        end
                    end else begin
                        if (!match_reg && active_reg[rd_idx_reg]
                                && rd_data.bssid == bssid_reg) begin
                            match_next = 1'b1;
                            match_idx_next = rd_idx_reg;
                            match_frames_next = rd_data.frames;
                        end
                        if (!free_reg && !active_reg[rd_idx_reg]) begin
                            free_next = 1'b1;
                            free_idx_next = rd_idx_reg;
                        end
                        if (rd_idx_reg == '0 || rd_data.rssi < weak_rssi_reg) begin
                            weak_idx_next = rd_idx_reg;
                            weak_rssi_next = rd_data.rssi;
                        end
                    end
                end
                if (scan_end) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_data.bssid = bssid_reg;
                wr_data.rssi = rssi_reg;
                wr_data.channel = chan_reg;
                wr_data.variance = var_reg;
                wr_data.last_seen = now_reg;
                wr_data.frames = 32'd1;
                if (mode_reg) begin
                    outcome_next = OUT_SWEEP;
                end else if (match_reg) begin
                    outcome_next = OUT_REFRESH;
                    wr_en = 1'b1;
                    wr_addr = match_idx_reg;
                    wr_data.frames = (match_frames_reg == 32'hFFFF_FFFF) ?
                        match_frames_reg : match_frames_reg + 32'd1;
                end else if (count_reg < CW'(ENTRIES) && free_reg) begin
                    outcome_next = OUT_INSERT;
                    wr_en = 1'b1;
                    wr_addr = free_idx_reg;
                    active_next[free_idx_reg] = 1'b1;
                    count_next = count_reg + CW'(1);
                end else if (rssi_reg > weak_rssi_reg) begin
                    outcome_next = OUT_REPLACE;
                    wr_en = 1'b1;
                    wr_addr = weak_idx_reg;
                    active_next[weak_idx_reg] = 1'b1;
                end else begin
                    outcome_next = OUT_DROP;
                end
                state_next = ST_BEST;
                cnt_next = '0;
                rd_vld_next = 1'b0;
                have_next = 1'b0;
                best_idx_next = '0;
                best_next = '0;
            end
            ST_BEST: begin
                if (rd_vld_reg && active_reg[rd_idx_reg]
                        && (!have_reg || rd_data.rssi > best_reg.rssi)) begin
                    have_next = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_next = rd_data;
                end
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            active_reg <= '0;
            count_reg <= '0;
            stale_reg <= STALE_RST;
            removal_reg <= REMOVAL_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            active_reg <= active_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_index == CFG_STALE) begin
                stale_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_REMOVAL) begin
                removal_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        match_reg <= match_next;
        match_idx_reg <= match_idx_next;
        match_frames_reg <= match_frames_next;
        free_reg <= free_next;
        free_idx_reg <= free_idx_next;
        weak_idx_reg <= weak_idx_next;
        weak_rssi_reg <= weak_rssi_next;
        outcome_reg <= outcome_next;
        have_reg <= have_next;
        best_idx_reg <= best_idx_next;
        best_reg <= best_next;
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            now_reg <= s_now_us;
            bssid_reg <= s_frame_bssid;
            rssi_reg <= s_frame_rssi;
            chan_reg <= s_frame_channel;
            var_reg <= s_frame_variance;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_outcome_reg <= outcome_reg;
            m_found_reg <= have_reg;
            m_index_reg <= 4'(best_idx_reg);
            m_entry_reg <= best_reg;
            m_count_reg <= 5'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_outcome = m_outcome_reg;
    assign m_found = m_found_reg;
    assign m_best_index = m_index_reg;
    assign m_best_bssid = m_entry_reg.bssid;
    assign m_best_rssi = m_entry_reg.rssi;
    assign m_best_channel = m_entry_reg.channel;
    assign m_best_variance = m_entry_reg.variance;
    assign m_best_frames = m_entry_reg.frames;
    assign m_occupied_count = m_count_reg;

endmodule
`default_nettype wire

// File: design/rret_table.sv
// Entry memory with per-slot valid bits; an unwritten or cleared slot reads as zero.
`default_nettype none
module rret_table #(
    parameter int ENTRIES = rret_pkg::ENTRIES_DEF,
    parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_en,
    input  wire logic [IW-1:0]   wr_addr,
    input  wire rret_pkg::entry_t wr_data,
    input  wire logic            clr_en,
    input  wire logic [IW-1:0]   clr_addr,
    input  wire logic [IW-1:0]   rd_addr,
    output rret_pkg::entry_t     rd_data
);
    import rret_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_word_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule
`default_nettype wire

// File: bench/rssi_ranked_entry_table_with_aging_test.sv
// Self-checking bench for the ranked station table: frame updates, sweeps and timeouts.
`default_nettype none
module rssi_ranked_entry_table_with_aging_test;
    import rret_pkg::*;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic              mode;
        logic [47:0]       now_us;
        logic [47:0]       bssid;
        logic signed [7:0] rssi;
        logic [7:0]        channel;
        logic [31:0]       variance;
    } frame_word_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic              found;
        logic [3:0]        best_index;
        logic [47:0]       best_bssid;
        logic signed [7:0] best_rssi;
        logic [7:0]        best_channel;
        logic [31:0]       best_variance;
        logic [31:0]       best_frames;
        logic [4:0]        occupied;
    } ranking_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [47:0] s_now_us = '0;
    logic [47:0] s_frame_bssid = '0;
    logic signed [7:0] s_frame_rssi = '0;
    logic [7:0] s_frame_channel = '0;
    logic [31:0] s_frame_variance = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_outcome;
    logic m_found;
    logic [3:0] m_best_index;
    logic [47:0] m_best_bssid;
    logic signed [7:0] m_best_rssi;
    logic [7:0] m_best_channel;
    logic [31:0] m_best_variance;
    logic [31:0] m_best_frames;
    logic [4:0] m_occupied_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    rssi_ranked_entry_table_with_aging i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_now_us(s_now_us),
        .s_frame_bssid(s_frame_bssid), .s_frame_rssi(s_frame_rssi),
        .s_frame_channel(s_frame_channel), .s_frame_variance(s_frame_variance),
        .m_valid(m_valid), .m_ready(m_ready), .m_outcome(m_outcome), .m_found(m_found),
        .m_best_index(m_best_index), .m_best_bssid(m_best_bssid),
        .m_best_rssi(m_best_rssi), .m_best_channel(m_best_channel),
        .m_best_variance(m_best_variance), .m_best_frames(m_best_frames),
        .m_occupied_count(m_occupied_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    entry_t tbl [NSLOT];
    logic tbl_active [NSLOT];
    int unsigned tbl_count;
    logic [47:0] stale_to, removal_to;

    frame_word_t pending_words[$];
    ranking_t expected_rankings[$];
    int errors = 0;
    int words_sent = 0, words_seen = 0, sweeps_sent = 0;
    int outcome_hits [5];
    bit hold_off = 1'b0;

    function automatic void store_frame(int i, frame_word_t w);
        tbl[i].bssid = w.bssid;
        tbl[i].rssi = w.rssi;
        tbl[i].channel = w.channel;
        tbl[i].variance = w.variance;
        tbl[i].last_seen = w.now_us;
    endfunction

    function automatic logic [2:0] apply_frame(frame_word_t w);
        int weak_slot;
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_active[i] && tbl[i].bssid == w.bssid) begin
                store_frame(i, w);
                if (tbl[i].frames != 32'hFFFF_FFFF) tbl[i].frames++;
                return OUT_REFRESH;
            end
        end
        if (tbl_count < NSLOT) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!tbl_active[i]) begin
                    store_frame(i, w);
                    tbl[i].frames = 1;
                    tbl_active[i] = 1'b1;
                    tbl_count++;
                    return OUT_INSERT;
                end
            end
        end
        weak_slot = 0;
        for (int i = 1; i < NSLOT; i++)
            if (tbl[i].rssi < tbl[weak_slot].rssi) weak_slot = i;
        if (w.rssi > tbl[weak_slot].rssi) begin
            store_frame(weak_slot, w);
            tbl[weak_slot].frames = 1;
            tbl_active[weak_slot] = 1'b1;
            return OUT_REPLACE;
        end
        return OUT_DROP;
    endfunction

    function automatic void age_table(logic [47:0] now);
        logic [47:0] age;
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_active[i]) begin
                age = now - tbl[i].last_seen;
                if (age > removal_to) begin
                    tbl[i] = '0;
                    tbl_active[i] = 1'b0;
                    if (tbl_count > 0) tbl_count--;
                end else if (age > stale_to) begin
                    tbl_active[i] = 1'b0;
                end
            end
        end
    endfunction

    function automatic ranking_t rank_table(frame_word_t w);
        ranking_t r;
        int best;
        r = '0;
        r.outcome = OUT_SWEEP;
        if (w.mode) age_table(w.now_us);
        else r.outcome = apply_frame(w);
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_active[i] && (best < 0 || tbl[i].rssi > tbl[best].rssi)) best = i;
        if (best >= 0) begin
            r.found = 1'b1;
            r.best_index = best[3:0];
            r.best_bssid = tbl[best].bssid;
            r.best_rssi = tbl[best].rssi;
            r.best_channel = tbl[best].channel;
            r.best_variance = tbl[best].variance;
            r.best_frames = tbl[best].frames;
        end
        r.occupied = tbl_count[4:0];
        return r;
    endfunction

    // driver: bursts with random gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_rankings.push_back(rank_table(pending_words.pop_front()));
                words_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0
                             && !(s_valid && s_ready && pending_words.size() == 0)) begin
                    s_valid <= 1'b1;
                    {s_mode, s_now_us, s_frame_bssid, s_frame_rssi, s_frame_channel,
                     s_frame_variance} <= pending_words[0];
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall pattern and compare
    int stall_phase = 0;
    always @(posedge aclk) begin
        ranking_t got, exp;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_outcome, m_found, m_best_index, m_best_bssid, m_best_rssi,
                       m_best_channel, m_best_variance, m_best_frames, m_occupied_count};
                words_seen++;
                if (expected_rankings.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    exp = expected_rankings.pop_front();
                    if (exp.outcome <= OUT_SWEEP) outcome_hits[exp.outcome]++;
                    if (got.outcome != exp.outcome) begin
                        $error("outcome exp %0d got %0d", exp.outcome, got.outcome); errors++;
                    end
                    if (got.found != exp.found) begin
                        $error("found exp %0d got %0d", exp.found, got.found); errors++;
                    end
                    if (got.best_index != exp.best_index) begin
                        $error("best_index exp %0d got %0d", exp.best_index, got.best_index);
                        errors++;
                    end
                    if (got.best_bssid != exp.best_bssid) begin
                        $error("best_bssid exp %h got %h", exp.best_bssid, got.best_bssid);
                        errors++;
                    end
                    if (got.best_rssi != exp.best_rssi) begin
                        $error("best_rssi exp %0d got %0d", exp.best_rssi, got.best_rssi);
                        errors++;
                    end
                    if (got.best_channel != exp.best_channel) begin
                        $error("best_channel exp %0d got %0d", exp.best_channel,
                               got.best_channel);
                        errors++;
                    end
                    if (got.best_variance != exp.best_variance) begin
                        $error("best_variance exp %h got %h", exp.best_variance,
                               got.best_variance);
                        errors++;
                    end
                    if (got.best_frames != exp.best_frames) begin
                        $error("best_frames exp %0d got %0d", exp.best_frames,
                               got.best_frames);
                        errors++;
                    end
                    if (got.occupied != exp.occupied) begin
                        $error("occupied_count exp %0d got %0d", exp.occupied,
                               got.occupied);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off) m_ready <= 1'b0;
            else if (stall_phase < 8) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // long receiver hold-off
    initial begin
        wait (aresetn);
        wait (words_sent > 250);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    task automatic write_reg(logic [7:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STALE) stale_to = val;
        else if (idx == CFG_REMOVAL) removal_to = val;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_rankings.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    function automatic frame_word_t make_frame(logic [47:0] now, logic [47:0] addr,
                                               logic [7:0] rssi);
        frame_word_t w;
        w.mode = 1'b0;
        w.now_us = now;
        w.bssid = addr;
        w.rssi = rssi;
        w.channel = 8'($urandom);
        w.variance = $urandom;
        return w;
    endfunction

    function automatic frame_word_t make_sweep(logic [47:0] now);
        frame_word_t w;
        logic [159:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = noise[144:0];
        w.mode = 1'b1;
        w.now_us = now;
        return w;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    task automatic random_phase(int n, int unsigned step_max);
        logic [47:0] clk_us;
        logic [47:0] pool [12];
        frame_word_t w;
        clk_us = rand48();
        foreach (pool[i]) pool[i] = rand48();
        for (int k = 0; k < n; k++) begin
            clk_us += 48'($urandom_range(0, step_max));
            if ($urandom_range(0, 9) == 0) begin
                pending_words.push_back(make_sweep(clk_us));
                sweeps_sent++;
            end else begin
                w = make_frame(clk_us, ($urandom_range(0, 4) == 0) ? rand48()
                               : pool[$urandom_range(0, 11)], 8'($urandom));
                pending_words.push_back(w);
            end
        end
    endtask

    initial begin
        frame_word_t w;
        foreach (tbl[i]) begin
            tbl[i] = '0;
            tbl_active[i] = 1'b0;
        end
        tbl_count = 0;
        stale_to = STALE_RST;
        removal_to = REMOVAL_RST;
        foreach (outcome_hits[i]) outcome_hits[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // sweep on empty table, extremes, fill, replace, drop, refresh
        pending_words.push_back(make_sweep(48'h0));
        pending_words.push_back(make_frame(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'h7F));
        pending_words.push_back(make_frame(48'h0, 48'h0, 8'h80));
        for (int i = 2; i < NSLOT; i++)
            pending_words.push_back(make_frame(48'd10, 48'd100 + i, 8'hC0));
        pending_words.push_back(make_frame(48'd20, 48'd500, 8'hB0));
        pending_words.push_back(make_frame(48'd20, 48'd501, 8'h80));
        pending_words.push_back(make_frame(48'd30, 48'hFFFF_FFFF_FFFF, 8'h7F));
        w = make_frame(48'd40, 48'd105, 8'hC0);
        w.channel = 8'hFF;
        w.variance = 32'hFFFF_FFFF;
        pending_words.push_back(w);
        // stale aging of every entry, then a later sweep over the stale table
        pending_words.push_back(make_sweep(48'd5_000_100));
        pending_words.push_back(make_sweep(48'd40_000_000));
        drain();

        write_reg(CFG_STALE, 48'd0);
        write_reg(CFG_REMOVAL, 48'hFFFF_FFFF_FFFF);
        random_phase(120, 3);
        drain();
        write_reg(CFG_STALE, 48'd50);
        write_reg(CFG_REMOVAL, 48'd200);
        random_phase(150, 40);
        drain();
        write_reg(CFG_STALE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_REMOVAL, 48'd0);
        random_phase(60, 10);
        drain();
        write_reg(CFG_STALE, STALE_RST);
        write_reg(CFG_REMOVAL, REMOVAL_RST);
        write_reg(8'hFF, rand48());
        random_phase(100, 2_000_000);
        drain();

        $display("%0d words sent (%0d sweeps), %0d results checked", words_sent,
                 sweeps_sent, words_seen);
        $display("outcomes: refresh %0d insert %0d replace %0d drop %0d sweep %0d",
                 outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
                 outcome_hits[4]);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
